FILE: src/assert_macros.svh
// Assertion macros used by the RTL of the colour correction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/pcc_pkg.sv
// Package of the colour correction block: widths, register indexes and reciprocal table.
package pcc_pkg;

  localparam int CHANNEL_BITS   = 8;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int RECIP_SHIFT    = 24;
  localparam int RECIP_BITS     = 25;
  localparam int NUM_CHANNELS   = 3;

  // Luma weights in Q.16
  localparam int LUMA_R = 19595;
  localparam int LUMA_G = 38470;
  localparam int LUMA_B = 7471;

  typedef logic [CHANNEL_BITS-1:0]   chan_t;
  typedef logic signed [7:0]         level_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [RECIP_BITS-1:0]     recip_t;
  typedef recip_t                    recip_tab_t [256];

  // Register indexes of the configuration port
  localparam cfg_index_t REG_BRIGHTNESS = 2'd0;
  localparam cfg_index_t REG_CONTRAST   = 2'd1;
  localparam cfg_index_t REG_SATURATION = 2'd2;

  // Build ceil(2^24 / a) for every alpha; entry zero is never used
  function automatic recip_tab_t recip_table_f();
    recip_tab_t tab;
    tab[0] = '0;
    for (int i = 1; i < 256; i++) begin
      tab[i] = recip_t'(((32'd1 << RECIP_SHIFT) + 32'(i) - 32'd1) / 32'(i));
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TABLE = recip_table_f();

endpackage

FILE: src/pcc_if.sv
// Stream interfaces of the colour correction block: source pixel and corrected pixel.
interface pcc_in_if;
  import pcc_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  chan_t alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

interface pcc_out_if;
  import pcc_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  chan_t alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

FILE: src/premultiplied_color_correction.sv
// Top level of the brightness, contrast and saturation correction of premultiplied pixels.
//
// Takes one premultiplied ARGB pixel per beat and returns it with brightness, contrast and
// saturation applied in Q.16 fixed point, then premultiplied again. A pixel with alpha zero
// passes unchanged. The block accepts one pixel every clock cycle while the output is not
// stalled; a stall at the output freezes the whole pipeline, so pixels are never lost or
// repeated. The depth is set by the unpremultiply division, done as three reciprocal
// multiply and remainder steps, one for the integer quotient and two of eight fraction bits
// each, followed by the contrast gain, luma sum, saturation mix and final premultiply, each
// behind a register. Configuration writes take effect on the next cycle and must be made
// while no pixel is in flight.
`include "assert_macros.svh"

module premultiplied_color_correction (
  input  logic                   clk,
  input  logic                   rst_n,
  pcc_in_if.sink                 in_ch,
  pcc_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  pcc_pkg::cfg_index_t    cfg_index,
  input  pcc_pkg::level_t        cfg_wdata
);
  import pcc_pkg::*;

  localparam int NUM_STAGES = 13;
  localparam int LAST       = NUM_STAGES - 1;

  typedef struct packed {
    logic  pass;
    chan_t alpha;
    chan_t red;
    chan_t green;
    chan_t blue;
  } ctl_t;

  // Clamp a raw register value to -100..100
  function automatic level_t clamp_level(input level_t raw);
    if (raw > 8'sd100) begin
      return 8'sd100;
    end else if (raw < -8'sd100) begin
      return -8'sd100;
    end
    return raw;
  endfunction

  // Gain floor((100 + level) * 65536 / 100) = v*655 + floor(9v/25)
  function automatic logic [17:0] gain_of(input level_t lvl);
    logic [7:0]  v;
    logic [10:0] w;
    logic [23:0] wm;
    v  = 8'(9'(lvl) + 9'sd100);
    w  = 11'(v) * 11'd9;
    wm = 24'(w) * 24'd5243;
    return 18'(v) * 18'd655 + 18'(wm[23:17]);
  endfunction

  // Offset floor(level * 255 * 65536 / 100) = level*167116 + floor(4*level/5)
  function automatic logic signed [25:0] offset_of(input level_t lvl);
    logic signed [10:0] ys;
    logic [25:0]        ym;
    logic [7:0]         fr;
    ys = 11'(lvl) * 11'sd4 + 11'sd400;
    ym = 26'(ys[9:0]) * 26'd52429;
    fr = ym[25:18];
    return 26'(lvl) * 26'sd167116 + $signed({18'b0, fr}) - 26'sd80;
  endfunction

  // Derived configuration
  logic signed [25:0] offset_r;
  logic [17:0]        gain_r;
  logic [17:0]        sat_gain_r;
  logic               sat_en_r;
  level_t             cfg_lvl;

  assign cfg_lvl = clamp_level(cfg_wdata);

  // Latch derived values on a register write; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      gain_r     <= 18'd65536;
      sat_gain_r <= 18'd65536;
      sat_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS: begin
          offset_r <= offset_of(cfg_lvl);
        end
        REG_CONTRAST: begin
          gain_r <= gain_of(cfg_lvl);
        end
        REG_SATURATION: begin
          sat_gain_r <= gain_of(cfg_lvl);
          sat_en_r   <= (cfg_lvl != 8'sd0);
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline control: every stage advances together unless the output beat is held
  logic [NUM_STAGES-1:0] valid_r;
  ctl_t                  ctl_r [NUM_STAGES];
  ctl_t                  ctl_nxt;
  logic                  adv;

  assign adv         = !valid_r[LAST] || out_ch.ready;
  // Refuse input beats while reset is held
  assign in_ch.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NUM_STAGES-2:0], in_ch.valid};
    end
  end

  assign ctl_nxt = '{pass:  (in_ch.alpha_in == '0),
                     alpha: in_ch.alpha_in,
                     red:   in_ch.red_in,
                     green: in_ch.green_in,
                     blue:  in_ch.blue_in};

  // Stage registers
  chan_t              in_col      [NUM_CHANNELS];
  logic [15:0]        s1_m_nxt    [NUM_CHANNELS];
  logic [40:0]        s1_p_nxt    [NUM_CHANNELS];
  logic [15:0]        s1_m_r      [NUM_CHANNELS];
  logic [40:0]        s1_p_r      [NUM_CHANNELS];
  logic [15:0]        s2_q1_nxt   [NUM_CHANNELS];
  logic [15:0]        s2_rem      [NUM_CHANNELS];
  logic [15:0]        s2_q1_r     [NUM_CHANNELS];
  logic [7:0]         s2_r1_r     [NUM_CHANNELS];
  logic [40:0]        s3_p_nxt    [NUM_CHANNELS];
  logic [15:0]        s3_q1_r     [NUM_CHANNELS];
  logic [7:0]         s3_r1_r     [NUM_CHANNELS];
  logic [40:0]        s3_p_r      [NUM_CHANNELS];
  logic [7:0]         s4_q2_nxt   [NUM_CHANNELS];
  logic [15:0]        s4_rem      [NUM_CHANNELS];
  logic [15:0]        s4_q1_r     [NUM_CHANNELS];
  logic [7:0]         s4_q2_r     [NUM_CHANNELS];
  logic [7:0]         s4_r2_r     [NUM_CHANNELS];
  logic [40:0]        s5_p_nxt    [NUM_CHANNELS];
  logic [15:0]        s5_q1_r     [NUM_CHANNELS];
  logic [7:0]         s5_q2_r     [NUM_CHANNELS];
  logic [40:0]        s5_p_r      [NUM_CHANNELS];
  logic signed [34:0] s6_t_nxt    [NUM_CHANNELS];
  logic signed [34:0] s6_t_r      [NUM_CHANNELS];
  logic signed [53:0] s7_prod_nxt [NUM_CHANNELS];
  logic signed [53:0] s7_prod_r   [NUM_CHANNELS];
  logic signed [35:0] s8_x_nxt    [NUM_CHANNELS];
  logic signed [35:0] s8_x_r      [NUM_CHANNELS];
  logic signed [52:0] s9_lp_nxt   [NUM_CHANNELS];
  logic signed [52:0] s9_lp_r     [NUM_CHANNELS];
  logic signed [35:0] s9_x_r      [NUM_CHANNELS];
  logic signed [53:0] s10_sum;
  logic signed [35:0] s10_luma_nxt;
  logic signed [36:0] s10_diff_nxt[NUM_CHANNELS];
  logic signed [35:0] s10_luma_r;
  logic signed [36:0] s10_diff_r  [NUM_CHANNELS];
  logic signed [35:0] s10_x_r     [NUM_CHANNELS];
  logic signed [55:0] s11_sd_nxt  [NUM_CHANNELS];
  logic signed [55:0] s11_sd_r    [NUM_CHANNELS];
  logic signed [35:0] s11_luma_r;
  logic signed [35:0] s11_x_r     [NUM_CHANNELS];
  logic signed [36:0] s12_ch      [NUM_CHANNELS];
  logic [23:0]        s12_cl      [NUM_CHANNELS];
  logic [31:0]        s12_mx_nxt  [NUM_CHANNELS];
  logic [31:0]        s12_mx_r    [NUM_CHANNELS];
  logic [15:0]        s13_m       [NUM_CHANNELS];
  logic [16:0]        s13_q       [NUM_CHANNELS];
  chan_t              s13_col_nxt [NUM_CHANNELS];
  chan_t              s13_col_r   [NUM_CHANNELS];
  chan_t              raw_col     [NUM_CHANNELS];
  logic signed [16:0] luma_coef   [NUM_CHANNELS];

  assign in_col[0]    = in_ch.red_in;
  assign in_col[1]    = in_ch.green_in;
  assign in_col[2]    = in_ch.blue_in;
  assign raw_col[0]   = ctl_r[LAST-1].red;
  assign raw_col[1]   = ctl_r[LAST-1].green;
  assign raw_col[2]   = ctl_r[LAST-1].blue;
  assign luma_coef[0] = 17'(LUMA_R);
  assign luma_coef[1] = 17'(LUMA_G);
  assign luma_coef[2] = 17'(LUMA_B);

  // Per-channel datapath between the stage registers
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      // Scale by 255 and multiply by the reciprocal for the integer quotient of c*255/a
      s1_m_nxt[i] = {in_col[i], 8'b0} - 16'(in_col[i]);
      s1_p_nxt[i] = 41'(s1_m_nxt[i]) * 41'(RECIP_TABLE[in_ch.alpha_in]);
      // Integer quotient and its remainder
      s2_q1_nxt[i] = s1_p_r[i][39:24];
      s2_rem[i]    = s1_m_r[i] - 16'(24'(s2_q1_nxt[i]) * 24'(ctl_r[0].alpha));
      // Upper eight fraction bits
      s3_p_nxt[i]  = 41'({s2_r1_r[i], 8'b0}) * 41'(RECIP_TABLE[ctl_r[1].alpha]);
      s4_q2_nxt[i] = s3_p_r[i][31:24];
      s4_rem[i]    = {s3_r1_r[i], 8'b0} - 16'(16'(s4_q2_nxt[i]) * 16'(ctl_r[2].alpha));
      // Lower eight fraction bits
      s5_p_nxt[i]  = 41'({s4_r2_r[i], 8'b0}) * 41'(RECIP_TABLE[ctl_r[3].alpha]);
      // Assemble the unpremultiplied value, add brightness, centre on mid grey
      s6_t_nxt[i]  = $signed({3'b0, s5_q1_r[i], s5_q2_r[i], s5_p_r[i][31:24]})
                     + 35'(offset_r) - 35'sd8388608;
      // Contrast gain
      s7_prod_nxt[i] = 54'(s6_t_r[i]) * 54'($signed({1'b0, gain_r}));
      s8_x_nxt[i]    = 36'(s7_prod_r[i] >>> FRAC_BITS) + 36'sd8388608;
      // Luma partial products
      s9_lp_nxt[i]   = 53'(s8_x_r[i]) * 53'(luma_coef[i]);
    end
    // Luma and distances from it
    s10_sum      = 54'(s9_lp_r[0]) + 54'(s9_lp_r[1]) + 54'(s9_lp_r[2]);
    s10_luma_nxt = 36'(s10_sum >>> FRAC_BITS);
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      s10_diff_nxt[i] = 37'(s9_x_r[i]) - 37'(s10_luma_nxt);
      // Saturation gain
      s11_sd_nxt[i]   = 56'(s10_diff_r[i]) * 56'($signed({1'b0, sat_gain_r}));
      // Mix, clamp and premultiply
      if (sat_en_r) begin
        s12_ch[i] = 37'(s11_luma_r) + 37'(s11_sd_r[i] >>> FRAC_BITS);
      end else begin
        s12_ch[i] = 37'(s11_x_r[i]);
      end
      if (s12_ch[i] < 37'sd0) begin
        s12_cl[i] = '0;
      end else if (s12_ch[i] > 37'sd16711680) begin
        s12_cl[i] = 24'hFF0000;
      end else begin
        s12_cl[i] = s12_ch[i][23:0];
      end
      s12_mx_nxt[i] = 32'(s12_cl[i]) * 32'(ctl_r[10].alpha);
      // Divide by 255*65536: drop the fraction, then exact divide by 255
      s13_m[i] = s12_mx_r[i][31:16];
      s13_q[i] = 17'(s13_m[i]) + 17'd1 + 17'(s13_m[i][15:8]);
      if (ctl_r[LAST-1].pass) begin
        s13_col_nxt[i] = raw_col[i];
      end else begin
        s13_col_nxt[i] = s13_q[i][15:8];
      end
    end
  end

  // Advance the payload of every stage
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_nxt;
      for (int k = 1; k < NUM_STAGES; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        s1_m_r[i]    <= s1_m_nxt[i];
        s1_p_r[i]    <= s1_p_nxt[i];
        s2_q1_r[i]   <= s2_q1_nxt[i];
        s2_r1_r[i]   <= s2_rem[i][7:0];
        s3_q1_r[i]   <= s2_q1_r[i];
        s3_r1_r[i]   <= s2_r1_r[i];
        s3_p_r[i]    <= s3_p_nxt[i];
        s4_q1_r[i]   <= s3_q1_r[i];
        s4_q2_r[i]   <= s4_q2_nxt[i];
        s4_r2_r[i]   <= s4_rem[i][7:0];
        s5_q1_r[i]   <= s4_q1_r[i];
        s5_q2_r[i]   <= s4_q2_r[i];
        s5_p_r[i]    <= s5_p_nxt[i];
        s6_t_r[i]    <= s6_t_nxt[i];
        s7_prod_r[i] <= s7_prod_nxt[i];
        s8_x_r[i]    <= s8_x_nxt[i];
        s9_lp_r[i]   <= s9_lp_nxt[i];
        s9_x_r[i]    <= s8_x_r[i];
        s10_diff_r[i]<= s10_diff_nxt[i];
        s10_x_r[i]   <= s9_x_r[i];
        s11_sd_r[i]  <= s11_sd_nxt[i];
        s11_x_r[i]   <= s10_x_r[i];
        s12_mx_r[i]  <= s12_mx_nxt[i];
        s13_col_r[i] <= s13_col_nxt[i];
      end
      s10_luma_r <= s10_luma_nxt;
      s11_luma_r <= s10_luma_r;
    end
  end

  // Drive the result channel from the last stage
  assign out_ch.valid     = valid_r[LAST];
  assign out_ch.red_out   = s13_col_r[0];
  assign out_ch.green_out = s13_col_r[1];
  assign out_ch.blue_out  = s13_col_r[2];
  assign out_ch.alpha_out = ctl_r[LAST].alpha;

  // Remainders of the reciprocal division stay below alpha
  `ASSERT_IMPLY(a_rem1_below_alpha, clk, rst_n, valid_r[1] && !ctl_r[1].pass, s2_r1_r[0] < ctl_r[1].alpha && s2_r1_r[1] < ctl_r[1].alpha && s2_r1_r[2] < ctl_r[1].alpha)
  `ASSERT_IMPLY(a_rem2_below_alpha, clk, rst_n, valid_r[3] && !ctl_r[3].pass, s4_r2_r[0] < ctl_r[3].alpha && s4_r2_r[1] < ctl_r[3].alpha && s4_r2_r[2] < ctl_r[3].alpha)
  // The red channel of a result never exceeds its alpha unless the pixel passes unchanged
  `ASSERT_IMPLY(a_col_le_alpha, clk, rst_n, out_ch.valid, out_ch.red_out <= out_ch.alpha_out || ctl_r[LAST].pass)
  // Saturation mix is enabled exactly for a non-zero level
  `ASSERT_NEXT(a_sat_en, clk, rst_n, cfg_we && cfg_index == REG_SATURATION, sat_en_r == ($past(cfg_wdata) != 8'sd0))
  // Gains stay within zero to two
  `ASSERT_HOLDS(a_gain_range, clk, rst_n, gain_r <= 18'd131072 && sat_gain_r <= 18'd131072)

endmodule

FILE: verif/tb_top.sv
// Testbench of the colour correction block: random and directed pixels checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import pcc_pkg::chan_t;
  import pcc_pkg::level_t;
  import pcc_pkg::cfg_index_t;
  import pcc_pkg::REG_BRIGHTNESS;
  import pcc_pkg::REG_CONTRAST;
  import pcc_pkg::REG_SATURATION;

  // Unmapped register index: writes to it are dropped
  localparam cfg_index_t REG_SPARE = 2'd3;

  // Q.16 fixed point
  localparam longint UNITY    = 64'sd65536;
  localparam longint MID_GREY = 128 * UNITY;
  localparam longint FULL     = 255 * UNITY;
  localparam longint WEIGHT_R = 19595;
  localparam longint WEIGHT_G = 38470;
  localparam longint WEIGHT_B = 7471;

  localparam int IDLE_PCT      = 35;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 200;
  localparam int BURSTS        = 12;
  localparam int BURST_PIXELS  = 103;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t a;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  cfg_index_t cfg_index;
  level_t     cfg_wdata;

  pcc_in_if  in_bus ();
  pcc_out_if out_bus ();

  premultiplied_color_correction dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Slider settings as the block holds them
  level_t lvl_bright   = '0;
  level_t lvl_contrast = '0;
  level_t lvl_sat      = '0;

  pixel_t source_px    [$];
  pixel_t predicted_px [$];
  int     pixels_sent  = 0;
  int     pixels_taken = 0;
  int     fail_count   = 0;
  logic   in_beat      = 1'b0;
  logic   calm         = 1'b0;
  int     rx_hold_req  = 0;
  int     rx_hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Division rounding toward minus infinity
  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  // Saturate a raw register value to the slider range
  function automatic longint level_value(level_t v);
    longint x;
    x = longint'(v);
    if (x > 100) x = 100;
    else if (x < -100) x = -100;
    return x;
  endfunction

  // Corrected premultiplied pixel for the current slider settings
  function automatic pixel_t correct_pixel(pixel_t p);
    longint ch [3];
    longint alpha, offset, gain, mix, luma, x;
    pixel_t res;
    res = p;
    alpha = longint'(p.a);
    if (alpha == 0) return res;
    offset = floor_quot(level_value(lvl_bright) * 255 * UNITY, 100);
    gain   = floor_quot((100 + level_value(lvl_contrast)) * UNITY, 100);
    ch[0] = longint'(p.r);
    ch[1] = longint'(p.g);
    ch[2] = longint'(p.b);
    // unpremultiply, brightness, contrast around mid grey
    for (int i = 0; i < 3; i++) begin
      x = floor_quot(ch[i] * 255 * UNITY, alpha) + offset;
      ch[i] = floor_quot((x - MID_GREY) * gain, UNITY) + MID_GREY;
    end
    // mix away from luma, skipped at zero saturation
    if (level_value(lvl_sat) != 0) begin
      mix  = floor_quot((100 + level_value(lvl_sat)) * UNITY, 100);
      luma = floor_quot(WEIGHT_R * ch[0] + WEIGHT_G * ch[1] + WEIGHT_B * ch[2], UNITY);
      for (int i = 0; i < 3; i++) ch[i] = luma + floor_quot(mix * (ch[i] - luma), UNITY);
    end
    // clamp and premultiply again
    for (int i = 0; i < 3; i++) begin
      x = ch[i];
      if (x < 0) x = 0;
      else if (x > FULL) x = FULL;
      ch[i] = (x * alpha) / FULL;
    end
    res.r = chan_t'(ch[0]);
    res.g = chan_t'(ch[1]);
    res.b = chan_t'(ch[2]);
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     kind;
    kind = $urandom_range(99);
    if (kind < 5) p.a = '0;
    else if (kind < 25) p.a = 8'd255;
    else p.a = chan_t'($urandom_range(255, 1));
    // well-formed premultiplied colour most of the time, raw colour otherwise
    if (kind >= 25 && kind < 85) begin
      p.r = chan_t'($urandom_range(p.a));
      p.g = chan_t'($urandom_range(p.a));
      p.b = chan_t'($urandom_range(p.a));
    end else begin
      p.r = chan_t'($urandom);
      p.g = chan_t'($urandom);
      p.b = chan_t'($urandom);
    end
    return p;
  endfunction

  function automatic level_t pick_level();
    case ($urandom_range(9))
      0:       return level_t'(-100);
      1:       return level_t'(100);
      2:       return '0;
      3:       return level_t'($urandom_range(155, 101));
      default: return level_t'(int'($urandom_range(200)) - 100);
    endcase
  endfunction

  task automatic queue_pixel(chan_t r, chan_t g, chan_t b, chan_t a);
    source_px.push_back('{r, g, b, a});
    pixels_sent++;
  endtask

  task automatic write_level(cfg_index_t idx, level_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BRIGHTNESS: lvl_bright   = val;
      REG_CONTRAST:   lvl_contrast = val;
      REG_SATURATION: lvl_sat      = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every pixel is taken and every result is back
  task automatic wait_idle();
    do @(negedge clk); while (pixels_taken != pixels_sent || predicted_px.size() != 0);
  endtask

  task automatic compare_chan(string name, chan_t want, chan_t got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Driver: offer queued pixels, hold each beat until taken
  always @(negedge clk) begin : drive_pixels
    pixel_t px;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_beat) begin
      if (source_px.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        px = source_px.pop_front();
        in_bus.red_in   <= px.r;
        in_bus.green_in <= px.g;
        in_bus.blue_in  <= px.b;
        in_bus.alpha_in <= px.a;
        in_bus.valid    <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus long hold-offs on request
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      out_bus.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on each input beat, check each output beat
  always @(posedge clk) begin : watch_beats
    pixel_t got;
    pixel_t want;
    in_beat = 1'b0;
    if (rst_n) begin
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
        predicted_px.push_back(correct_pixel('{in_bus.red_in, in_bus.green_in,
                                                in_bus.blue_in, in_bus.alpha_in}));
        pixels_taken++;
        in_beat = 1'b1;
      end
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got = '{out_bus.red_out, out_bus.green_out, out_bus.blue_out, out_bus.alpha_out};
        if (predicted_px.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result beat with none pending, expected nothing, got %h",
                     $time, got);
        end else begin
          want = predicted_px.pop_front();
          compare_chan("red_out",   want.r, got.r);
          compare_chan("green_out", want.g, got.g);
          compare_chan("blue_out",  want.b, got.b);
          compare_chan("alpha_out", want.a, got.a);
        end
      end
    end
  end

  initial begin
    #(4_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_BRIGHTNESS;
    cfg_wdata       = '0;
    in_bus.valid    = 1'b0;
    in_bus.red_in   = '0;
    in_bus.green_in = '0;
    in_bus.blue_in  = '0;
    in_bus.alpha_in = '0;
    out_bus.ready   = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: alpha zero pass-through, extremes, colour above alpha
    @(posedge clk);
    queue_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd170, 8'd85,  8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0,   8'd0,   8'd0,   8'd255);
    queue_pixel(8'd255, 8'd0,   8'd255, 8'd1);
    queue_pixel(8'd1,   8'd0,   8'd1,   8'd1);
    queue_pixel(8'd128, 8'd64,  8'd32,  8'd128);
    queue_pixel(8'd200, 8'd10,  8'd90,  8'd200);
    wait_idle();

    // Slider extremes
    write_level(REG_BRIGHTNESS, level_t'(100));
    write_level(REG_CONTRAST,   level_t'(-100));
    write_level(REG_SATURATION, level_t'(100));
    @(posedge clk);
    queue_pixel(8'd0,   8'd0,   8'd0,   8'd255);
    queue_pixel(8'd255, 8'd0,   8'd0,   8'd255);
    queue_pixel(8'd12,  8'd200, 8'd77,  8'd200);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd3);
    queue_pixel(8'd40,  8'd41,  8'd42,  8'd0);
    queue_pixel(8'd1,   8'd2,   8'd3,   8'd4);
    wait_idle();

    // Raw values beyond the slider range saturate; the spare index is ignored
    write_level(REG_BRIGHTNESS, level_t'(-128));
    write_level(REG_CONTRAST,   level_t'(127));
    write_level(REG_SATURATION, level_t'(-101));
    write_level(REG_SPARE,      level_t'(90));
    @(posedge clk);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0,   8'd128, 8'd255, 8'd255);
    queue_pixel(8'd100, 8'd50,  8'd25,  8'd100);
    queue_pixel(8'd255, 8'd0,   8'd128, 8'd64);
    queue_pixel(8'd7,   8'd7,   8'd7,   8'd7);
    queue_pixel(8'd9,   8'd9,   8'd9,   8'd0);
    wait_idle();

    // Random bursts, each under fresh slider settings
    for (int n = 0; n < BURSTS; n++) begin
      write_level(REG_BRIGHTNESS, pick_level());
      write_level(REG_CONTRAST,   pick_level());
      write_level(REG_SATURATION, pick_level());
      if ($urandom_range(3) == 0) write_level(REG_SPARE, level_t'($urandom));
      @(posedge clk);
      for (int k = 0; k < BURST_PIXELS; k++) source_px.push_back(random_pixel());
      pixels_sent += BURST_PIXELS;
      // one burst without idling, one with a long receiver hold-off
      if (n == 3) calm = 1'b1;
      if (n == 7) rx_hold_req = 300;
      wait_idle();
      @(posedge clk);
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && predicted_px.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
